// File: design/hlb_pkg.sv
package hlb_pkg;

    // Field widths of the item and result ports
    localparam int NODE_W  = 5;
    localparam int COORD_W = 17;
    localparam int OUT_W   = 20;
    localparam int ORDER_W = 2;

    // Default number of fraction bits
    localparam int FRAC_BITS_DEFAULT = 16;

    // Output saturation limits
    localparam int OUT_MAX = 524287;
    localparam int OUT_MIN = -524288;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic CFG_IDX_ORDER = 1'b0;

    // Element order codes
    localparam logic [ORDER_W-1:0] ORDER_LINEAR = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_QUAD   = 2'd2;

    // Node counts per order
    localparam int NODES_LINEAR = 8;
    localparam int NODES_QUAD   = 27;

    // 1D node position along one axis: 0, 1 (mid) or 2
    typedef logic [1:0] axis_pos_t;

    typedef struct packed {
        axis_pos_t kx;
        axis_pos_t ky;
        axis_pos_t kz;
    } node_axes_t;

    // Per-axis control handed to each axis unit
    typedef struct packed {
        logic      quad;
        axis_pos_t k;
    } axis_ctl_t;

    // Per-axis positions of the triquadratic nodes; linear nodes use bit 1
    function automatic node_axes_t node_axis(input logic [NODE_W-1:0] node);
        node_axes_t r;
        unique case (node)
            5'd0:    r = '{2'd0, 2'd0, 2'd0};
            5'd1:    r = '{2'd2, 2'd0, 2'd0};
            5'd2:    r = '{2'd2, 2'd2, 2'd0};
            5'd3:    r = '{2'd0, 2'd2, 2'd0};
            5'd4:    r = '{2'd0, 2'd0, 2'd2};
            5'd5:    r = '{2'd2, 2'd0, 2'd2};
            5'd6:    r = '{2'd2, 2'd2, 2'd2};
            5'd7:    r = '{2'd0, 2'd2, 2'd2};
            5'd8:    r = '{2'd1, 2'd0, 2'd0};
            5'd9:    r = '{2'd2, 2'd1, 2'd0};
            5'd10:   r = '{2'd1, 2'd2, 2'd0};
            5'd11:   r = '{2'd0, 2'd1, 2'd0};
            5'd12:   r = '{2'd0, 2'd0, 2'd1};
            5'd13:   r = '{2'd2, 2'd0, 2'd1};
            5'd14:   r = '{2'd2, 2'd2, 2'd1};
            5'd15:   r = '{2'd0, 2'd2, 2'd1};
            5'd16:   r = '{2'd1, 2'd0, 2'd2};
            5'd17:   r = '{2'd2, 2'd1, 2'd2};
            5'd18:   r = '{2'd1, 2'd2, 2'd2};
            5'd19:   r = '{2'd0, 2'd1, 2'd2};
            5'd20:   r = '{2'd0, 2'd1, 2'd1};
            5'd21:   r = '{2'd2, 2'd1, 2'd1};
            5'd22:   r = '{2'd1, 2'd0, 2'd1};
            5'd23:   r = '{2'd1, 2'd2, 2'd1};
            5'd24:   r = '{2'd1, 2'd1, 2'd0};
            5'd25:   r = '{2'd1, 2'd1, 2'd2};
            5'd26:   r = '{2'd1, 2'd1, 2'd1};
            default: r = '{2'd0, 2'd0, 2'd0};
        endcase
        return r;
    endfunction

endpackage

// File: design/hlb_axis.sv
module hlb_axis #(
    parameter int FRAC_BITS = hlb_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                          clk,
    input  hlb_pkg::axis_ctl_t            ctl,
    input  logic [hlb_pkg::COORD_W-1:0]   coord,
    output logic signed [FRAC_BITS+1:0]   val,
    output logic signed [FRAC_BITS+3:0]   der
);

    localparam int TW = (FRAC_BITS + 1 > hlb_pkg::COORD_W) ? FRAC_BITS + 1 : hlb_pkg::COORD_W;
    localparam int AW = TW + 2;
    localparam int MW = 2 * AW;
    localparam int PW = MW + 2;
    localparam int VW = FRAC_BITS + 2;
    localparam int DW = FRAC_BITS + 4;

    localparam logic [TW-1:0]        ONE_T  = TW'(1) << FRAC_BITS;
    localparam logic signed [AW-1:0] ONE_A  = AW'(ONE_T);
    localparam logic signed [DW-1:0] ONE_D  = DW'(1) <<< FRAC_BITS;
    localparam logic signed [VW-1:0] ONE_V  = VW'(1) <<< FRAC_BITS;
    localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (FRAC_BITS - 1);

    logic [TW-1:0]        raw_ext;
    logic [TW-1:0]        t;
    logic signed [AW-1:0] ta;
    logic signed [DW-1:0] td;
    logic signed [VW-1:0] tv;

    logic signed [AW-1:0] a_next;
    logic signed [AW-1:0] b_next;
    logic signed [DW-1:0] der_a_next;
    logic signed [VW-1:0] lin_a_next;

    logic signed [AW-1:0] a_reg;
    logic signed [AW-1:0] b_reg;
    logic                 quad_a_reg;
    logic                 sc_a_reg;
    logic signed [VW-1:0] lin_a_reg;
    logic signed [DW-1:0] der_a_reg;

    logic signed [MW-1:0] prod_reg;
    logic                 quad_b_reg;
    logic                 sc_b_reg;
    logic signed [VW-1:0] lin_b_reg;
    logic signed [DW-1:0] der_b_reg;

    logic signed [PW-1:0] p_sel;
    logic signed [PW-1:0] p_neg;
    logic signed [PW-1:0] p_sum;
    logic signed [PW-1:0] p_rnd;
    logic signed [VW-1:0] val_next;

    logic signed [VW-1:0] val_reg;
    logic signed [DW-1:0] der_reg;

    // Clamp the coordinate to one
    assign raw_ext = TW'(coord);
    assign t       = (raw_ext > ONE_T) ? ONE_T : raw_ext;
    assign ta      = $signed(AW'(t));
    assign td      = $signed(DW'(t));
    assign tv      = $signed(VW'(t));

    // Pick multiplier operands and the derivative for this node position
    always_comb
    begin
        a_next     = '0;
        b_next     = '0;
        der_a_next = '0;
        lin_a_next = ctl.k[1] ? tv : ONE_V - tv;
        if (ctl.quad)
        begin
            unique case (ctl.k)
                2'd0:
                begin
                    a_next     = ONE_A - ta;
                    b_next     = ONE_A - (ta <<< 1);
                    der_a_next = (td <<< 2) - ONE_D - (ONE_D <<< 1);
                end
                2'd1:
                begin
                    a_next     = ta;
                    b_next     = ONE_A - ta;
                    der_a_next = (ONE_D <<< 2) - (td <<< 3);
                end
                default:
                begin
                    a_next     = ta;
                    b_next     = (ta <<< 1) - ONE_A;
                    der_a_next = (td <<< 2) - ONE_D;
                end
            endcase
        end
        else
        begin
            der_a_next = ctl.k[1] ? ONE_D : -ONE_D;
        end
    end

    // Operand stage
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        quad_a_reg <= ctl.quad;
        sc_a_reg   <= (ctl.k == 2'd1);
        lin_a_reg  <= lin_a_next;
        der_a_reg  <= der_a_next;
    end

    // Multiply stage
    always_ff @(posedge clk)
    begin
        prod_reg   <= a_reg * b_reg;
        quad_b_reg <= quad_a_reg;
        sc_b_reg   <= sc_a_reg;
        lin_b_reg  <= lin_a_reg;
        der_b_reg  <= der_a_reg;
    end

    // Scale the mid-node product by four, then round half away from zero
    assign p_sel    = sc_b_reg ? (PW'(prod_reg) <<< 2) : PW'(prod_reg);
    assign p_neg    = $signed(PW'(p_sel[PW-1]));
    assign p_sum    = p_sel + HALF_P - p_neg;
    assign p_rnd    = p_sum >>> FRAC_BITS;
    assign val_next = quad_b_reg ? VW'(p_rnd) : lin_b_reg;

    // Result stage
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        der_reg <= der_b_reg;
    end

    assign val = val_reg;
    assign der = der_reg;

endmodule

// File: design/hex_lagrange_basis_eval.sv
// Hexahedron Lagrange shape function evaluator, trilinear or triquadratic.
//
// Item channel: drive node_index and coord_x/y/z with start high; the item is
// taken at a rising edge where start is high and busy is low. busy stays low,
// so a new item may be taken in every cycle.
// Result channel: done is high for exactly one cycle with shape_value,
// grad_x, grad_y, grad_z and bad_node; the receiver must take it then.
// Pipeline: results leave in the order items came in. Throughput is one
// item per cycle; the eight registers are the decode register, three
// stages per axis (operand select, 1D product, rounding), then pair
// product, rounding, final product, and rounding with saturation into the
// output register.
// Configuration: APB register element_order at byte address 0 (1 = trilinear,
// 2 = triquadratic, other codes flag every item as a bad node). Write it
// only while no transaction is in flight.
// Reset: element_order returns to 1 and the pipeline drops all transactions
// in flight; no result is lost through backpressure since there is none.
module hex_lagrange_basis_eval #(
    parameter int FRAC_BITS = hlb_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hlb_pkg::PADDR_W-1:0]         paddr,
    input  logic [hlb_pkg::PDATA_W-1:0]         pwdata,
    output logic [hlb_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic [hlb_pkg::NODE_W-1:0]          node_index,
    input  logic [hlb_pkg::COORD_W-1:0]         coord_x,
    input  logic [hlb_pkg::COORD_W-1:0]         coord_y,
    input  logic [hlb_pkg::COORD_W-1:0]         coord_z,
    output logic                                done,
    output logic signed [hlb_pkg::OUT_W-1:0]    shape_value,
    output logic signed [hlb_pkg::OUT_W-1:0]    grad_x,
    output logic signed [hlb_pkg::OUT_W-1:0]    grad_y,
    output logic signed [hlb_pkg::OUT_W-1:0]    grad_z,
    output logic                                bad_node
);

    localparam int VW     = FRAC_BITS + 2;
    localparam int DW     = FRAC_BITS + 4;
    localparam int XW     = 2 * VW;
    localparam int QW     = VW + DW;
    localparam int STAGES = 7;
    localparam int OUT_W  = hlb_pkg::OUT_W;

    localparam logic signed [XW-1:0] HALF_X = XW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [QW-1:0] HALF_Q = QW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [QW-1:0] SAT_HI = QW'(hlb_pkg::OUT_MAX);
    localparam logic signed [QW-1:0] SAT_LO = QW'(hlb_pkg::OUT_MIN);

    logic [hlb_pkg::ORDER_W-1:0] element_order_reg;
    logic                        cfg_wr;

    logic                        accept;
    logic                        bad_next;
    logic                        quad_next;
    hlb_pkg::node_axes_t         axes_next;

    logic                        vld_reg [STAGES];
    logic                        bad_reg [STAGES];
    hlb_pkg::axis_ctl_t          ctl_reg [3];
    logic [hlb_pkg::COORD_W-1:0] coord_reg [3];

    logic signed [VW-1:0]        v [3];
    logic signed [DW-1:0]        d [3];

    logic signed [XW-1:0]        pxy_reg;
    logic signed [XW-1:0]        pxz_reg;
    logic signed [XW-1:0]        pyz_reg;
    logic signed [VW-1:0]        v2_p_reg;
    logic signed [DW-1:0]        d_p_reg [3];

    logic signed [XW-1:0]        pair_neg [3];
    logic signed [XW-1:0]        pair_sum [3];
    logic signed [XW-1:0]        pair_rnd [3];
    logic signed [XW-1:0]        pair_in  [3];

    logic signed [VW-1:0]        xy_reg;
    logic signed [VW-1:0]        xz_reg;
    logic signed [VW-1:0]        yz_reg;
    logic signed [VW-1:0]        v2_r_reg;
    logic signed [DW-1:0]        d_r_reg [3];

    logic signed [QW-1:0]        fin_reg [4];
    logic signed [QW-1:0]        fin_neg [4];
    logic signed [QW-1:0]        fin_sum [4];
    logic signed [QW-1:0]        fin_rnd [4];
    logic signed [OUT_W-1:0]     sat_next [4];

    logic                        done_reg;
    logic                        bad_out_reg;
    logic signed [OUT_W-1:0]     res_reg [4];

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == hlb_pkg::CFG_IDX_ORDER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_order_reg <= hlb_pkg::ORDER_LINEAR;
        end
        else if (cfg_wr)
        begin
            element_order_reg <= pwdata[hlb_pkg::ORDER_W-1:0];
        end
    end

    assign prdata = (paddr[2] == hlb_pkg::CFG_IDX_ORDER) ?
                    hlb_pkg::PDATA_W'(element_order_reg) : '0;

    // Accept a transaction in every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Decode the node against the selected order
    always_comb
    begin
        quad_next = (element_order_reg == hlb_pkg::ORDER_QUAD);
        axes_next = hlb_pkg::node_axis(node_index);
        priority if (element_order_reg == hlb_pkg::ORDER_LINEAR)
        begin
            bad_next = (node_index >= hlb_pkg::NODE_W'(hlb_pkg::NODES_LINEAR));
        end
        else if (element_order_reg == hlb_pkg::ORDER_QUAD)
        begin
            bad_next = (node_index >= hlb_pkg::NODE_W'(hlb_pkg::NODES_QUAD));
        end
        else
        begin
            bad_next = 1'b1;
        end
    end

    // Valid and error flags travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int i = 1; i < STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            done_reg <= vld_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        bad_reg[0] <= bad_next;
        for (int i = 1; i < STAGES; i++)
        begin
            bad_reg[i] <= bad_reg[i-1];
        end
    end

    // Decode stage
    always_ff @(posedge clk)
    begin
        ctl_reg[0]   <= '{quad: quad_next, k: axes_next.kx};
        ctl_reg[1]   <= '{quad: quad_next, k: axes_next.ky};
        ctl_reg[2]   <= '{quad: quad_next, k: axes_next.kz};
        coord_reg[0] <= coord_x;
        coord_reg[1] <= coord_y;
        coord_reg[2] <= coord_z;
    end

    // 1D factors per axis
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        hlb_axis #(
            .FRAC_BITS(FRAC_BITS)
        ) u_axis (
            .clk   (clk),
            .ctl   (ctl_reg[a]),
            .coord (coord_reg[a]),
            .val   (v[a]),
            .der   (d[a])
        );
    end

    // Pair products
    always_ff @(posedge clk)
    begin
        pxy_reg  <= v[0] * v[1];
        pxz_reg  <= v[0] * v[2];
        pyz_reg  <= v[1] * v[2];
        v2_p_reg <= v[2];
        for (int i = 0; i < 3; i++)
        begin
            d_p_reg[i] <= d[i];
        end
    end

    // Round pair products half away from zero
    assign pair_in[0] = pxy_reg;
    assign pair_in[1] = pxz_reg;
    assign pair_in[2] = pyz_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pair_neg[i] = $signed(XW'(pair_in[i][XW-1]));
            pair_sum[i] = pair_in[i] + HALF_X - pair_neg[i];
            pair_rnd[i] = pair_sum[i] >>> FRAC_BITS;
        end
    end

    always_ff @(posedge clk)
    begin
        xy_reg   <= VW'(pair_rnd[0]);
        xz_reg   <= VW'(pair_rnd[1]);
        yz_reg   <= VW'(pair_rnd[2]);
        v2_r_reg <= v2_p_reg;
        for (int i = 0; i < 3; i++)
        begin
            d_r_reg[i] <= d_p_reg[i];
        end
    end

    // Final products: value, then gradient along x, y, z
    always_ff @(posedge clk)
    begin
        fin_reg[0] <= QW'(xy_reg) * QW'(v2_r_reg);
        fin_reg[1] <= yz_reg * d_r_reg[0];
        fin_reg[2] <= xz_reg * d_r_reg[1];
        fin_reg[3] <= xy_reg * d_r_reg[2];
    end

    // Round and saturate into the output range
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            fin_neg[i] = $signed(QW'(fin_reg[i][QW-1]));
            fin_sum[i] = fin_reg[i] + HALF_Q - fin_neg[i];
            fin_rnd[i] = fin_sum[i] >>> FRAC_BITS;
            priority if (fin_rnd[i] > SAT_HI)
            begin
                sat_next[i] = OUT_W'(SAT_HI);
            end
            else if (fin_rnd[i] < SAT_LO)
            begin
                sat_next[i] = OUT_W'(SAT_LO);
            end
            else
            begin
                sat_next[i] = OUT_W'(fin_rnd[i]);
            end
        end
    end

    // Output register; a bad node gives zeros
    always_ff @(posedge clk)
    begin
        bad_out_reg <= bad_reg[STAGES-1];
        for (int i = 0; i < 4; i++)
        begin
            res_reg[i] <= bad_reg[STAGES-1] ? '0 : sat_next[i];
        end
    end

    assign done        = done_reg;
    assign bad_node    = bad_out_reg;
    assign shape_value = res_reg[0];
    assign grad_x      = res_reg[1];
    assign grad_y      = res_reg[2];
    assign grad_z      = res_reg[3];

`ifndef SYNTHESIS
    // Every taken transaction comes out with a result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##7 done)
        else $error("result strobe missing after accepted transaction");

    // No result without a transaction in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vld_reg[STAGES-1]))
        else $error("result strobe without a transaction");

    // A flagged node carries all-zero numeric fields
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_node) |-> (shape_value == '0 && grad_x == '0 &&
                                grad_y == '0 && grad_z == '0))
        else $error("bad node result carries nonzero fields");

    // A vertex under the trilinear order is never flagged
    a_linear_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && element_order_reg == hlb_pkg::ORDER_LINEAR &&
         node_index < hlb_pkg::NODE_W'(hlb_pkg::NODES_LINEAR)) |=> ##7 (done && !bad_node))
        else $error("valid trilinear node flagged as bad");
`endif

endmodule
